// ----- hw/rtl/mqtt_hdr_pkg.sv -----
// Shared constants and payload types for the MQTT inbound fixed-header parser.
// No dependencies; compiled first.
`default_nettype none

package mqtt_hdr_pkg;

  localparam int unsigned LEN_W            = 28;   // remaining length width
  localparam int unsigned MAX_LENGTH_BYTES = 4;    // length bytes before forced completion
  localparam logic [3:0]  CONNACK_TYPE     = 4'd2;
  localparam logic [7:0]  NO_CODE          = 8'hFF;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       chunk_start;
  } rx_item_t;

  typedef struct packed {
    logic [3:0]       packet_type;
    logic [LEN_W-1:0] remaining_length;
    logic             is_connack;
    logic [7:0]       connack_code;
  } pkt_item_t;

endpackage

`default_nettype wire

// ----- hw/rtl/mqtt_hdr_rx_if.sv -----
// Input channel: one received byte per transaction, valid/ready handshake.
// No dependencies.
`default_nettype none

interface mqtt_hdr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       chunk_start;

  modport source (output valid, output data_byte, output chunk_start, input ready);
  modport sink   (input valid, input data_byte, input chunk_start, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/mqtt_hdr_pkt_if.sv -----
// Output channel: one completed packet header per transaction, valid/ready.
// Depends on mqtt_hdr_pkg.
`default_nettype none

interface mqtt_hdr_pkt_if;
  logic                          valid;
  logic                          ready;
  logic [3:0]                    packet_type;
  logic [mqtt_hdr_pkg::LEN_W-1:0] remaining_length;
  logic                          is_connack;
  logic [7:0]                    connack_code;

  modport source (output valid, output packet_type, output remaining_length,
                  output is_connack, output connack_code, input ready);
  modport sink   (input valid, input packet_type, input remaining_length,
                  input is_connack, input connack_code, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/mqtt_inbound_header_parser_core.sv -----
// MQTT inbound fixed-header parser, top level.
// Depends on mqtt_hdr_pkg, mqtt_hdr_rx_if, mqtt_hdr_pkt_if.
`default_nettype none

// Splits a received byte stream into MQTT packets and reports one header
// transaction per completed packet: type nibble, decoded remaining length
// (7 bits per length byte, LSB group first, at most four length bytes, the
// fourth always ends the field), a CONNACK flag, and for a CONNACK the return
// code (second body byte, 0xFF if the body is shorter; 0 for other types).
// A packet with a zero remaining length completes on its last length byte.
// A byte with chunk_start set drops any partial packet without a result and
// is taken as a new type byte. Throughput is one byte per clock while rx.ready
// is high: each byte updates a handful of small parser registers. A packet's
// result is registered into the output register, or into the skid register
// if that is full. The output side is thus a two-entry buffer, so rx keeps
// accepting while one result waits; rx.ready drops only when both entries
// hold results that pkt has not taken.
module mqtt_inbound_header_parser_core (
  input  wire logic      clk,
  input  wire logic      rst,
  mqtt_hdr_rx_if.sink    rx,
  mqtt_hdr_pkt_if.source pkt
);

  localparam int unsigned LW = mqtt_hdr_pkg::LEN_W;

  typedef enum logic [1:0] {
    PH_TYPE = 2'd0,
    PH_LEN  = 2'd1,
    PH_BODY = 2'd2
  } phase_t;

  // parser state
  phase_t          phase;
  logic [3:0]      type_nibble;
  logic [LW-1:0]   length_accum;
  logic [2:0]      length_byte_count;
  logic [LW-1:0]   body_remaining;
  logic [1:0]      body_index;
  logic [7:0]      captured_code;

  // output buffer
  mqtt_hdr_pkg::pkt_item_t out_data;
  logic                    out_valid;
  mqtt_hdr_pkg::pkt_item_t skid_data;
  logic                    skid_valid;

  mqtt_hdr_pkg::rx_item_t  item;
  mqtt_hdr_pkg::pkt_item_t res;

  phase_t          phase_eff;
  logic            acc;
  logic            take;
  logic            emit;
  logic [LW-1:0]   len_grp;
  logic [LW-1:0]   length_accum_next;
  logic [2:0]      length_byte_count_next;
  logic            len_done;
  logic [LW-1:0]   body_remaining_next;
  logic [7:0]      captured_code_next;
  logic            load_out;

  assign item.data_byte   = rx.data_byte;
  assign item.chunk_start = rx.chunk_start;

  assign rx.ready = !skid_valid;
  assign acc      = rx.valid && rx.ready;
  assign take     = out_valid && pkt.ready;

  // chunk start forces a fresh packet; the unused phase code behaves the same
  always_comb begin
    if (item.chunk_start) begin
      phase_eff = PH_TYPE;
    end else begin
      case (phase)
        PH_LEN:  phase_eff = PH_LEN;
        PH_BODY: phase_eff = PH_BODY;
        default: phase_eff = PH_TYPE;
      endcase
    end
  end

  // place this length byte's 7-bit group by its position
  always_comb begin
    case (length_byte_count[1:0])
      2'd0:    len_grp = {21'd0, item.data_byte[6:0]};
      2'd1:    len_grp = {14'd0, item.data_byte[6:0], 7'd0};
      2'd2:    len_grp = {7'd0, item.data_byte[6:0], 14'd0};
      default: len_grp = {item.data_byte[6:0], 21'd0};
    endcase
  end

  assign length_accum_next      = length_accum | len_grp;
  assign length_byte_count_next = length_byte_count + 3'd1;
  assign len_done = !item.data_byte[7] ||
                    (length_byte_count_next >= 3'(mqtt_hdr_pkg::MAX_LENGTH_BYTES));
  assign body_remaining_next = body_remaining - LW'(1);
  assign captured_code_next  = (body_index == 2'd1) ? item.data_byte : captured_code;

  always_comb begin
    emit = 1'b0;
    res.packet_type      = type_nibble;
    res.remaining_length = length_accum;
    res.is_connack       = (type_nibble == mqtt_hdr_pkg::CONNACK_TYPE);
    res.connack_code     = 8'd0;
    case (phase_eff)
      PH_LEN: begin
        emit = len_done && (length_accum_next == '0);
        res.remaining_length = length_accum_next;
        // empty body: code was never seen
        res.connack_code = res.is_connack ? captured_code : 8'd0;
      end
      PH_BODY: begin
        emit = (body_remaining_next == '0);
        res.connack_code = res.is_connack ? captured_code_next : 8'd0;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  assign load_out = !out_valid || (take && !skid_valid);

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_TYPE;
      type_nibble       <= 4'd0;
      length_accum      <= '0;
      length_byte_count <= 3'd0;
      body_remaining    <= '0;
      body_index        <= 2'd0;
      captured_code     <= mqtt_hdr_pkg::NO_CODE;
    end else if (acc) begin
      case (phase_eff)
        PH_LEN: begin
          length_accum      <= length_accum_next;
          length_byte_count <= length_byte_count_next;
          if (len_done) begin
            if (length_accum_next == '0) begin
              phase <= PH_TYPE;
            end else begin
              body_remaining <= length_accum_next;
              phase          <= PH_BODY;
            end
          end else begin
            phase <= PH_LEN;
          end
        end
        PH_BODY: begin
          captured_code  <= captured_code_next;
          body_remaining <= body_remaining_next;
          if (body_index != 2'd2) begin
            body_index <= body_index + 2'd1;
          end
          phase <= emit ? PH_TYPE : PH_BODY;
        end
        default: begin
          type_nibble       <= item.data_byte[7:4];
          length_accum      <= '0;
          length_byte_count <= 3'd0;
          body_remaining    <= '0;
          body_index        <= 2'd0;
          captured_code     <= mqtt_hdr_pkg::NO_CODE;
          phase             <= PH_LEN;
        end
      endcase
    end
  end

  // two-entry output buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (take && skid_valid) begin
      // skid refills the output register; rx is held off this cycle
      out_data   <= skid_data;
      skid_valid <= 1'b0;
    end else if (acc && emit) begin
      if (load_out) begin
        out_data  <= res;
        out_valid <= 1'b1;
      end else begin
        skid_data  <= res;
        skid_valid <= 1'b1;
      end
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

  assign pkt.valid            = out_valid;
  assign pkt.packet_type      = out_data.packet_type;
  assign pkt.remaining_length = out_data.remaining_length;
  assign pkt.is_connack       = out_data.is_connack;
  assign pkt.connack_code     = out_data.connack_code;

  // skid entry only ever backs up a full output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry valid while output register empty");

  // a result arriving at a stalled, full output register lands in skid
  a_stall_to_skid: assert property (@(posedge clk) disable iff (rst)
    (acc && emit && out_valid && !pkt.ready) |=> skid_valid)
    else $error("result lost behind stalled output");

  // completing a packet returns the parser to the type byte
  a_emit_resets_phase: assert property (@(posedge clk) disable iff (rst)
    (acc && emit) |=> (phase == PH_TYPE))
    else $error("parser not back at type byte after a result");

  // body phase always has bytes left to count
  a_body_nonzero: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_BODY) |-> (body_remaining != '0))
    else $error("body phase with zero bytes remaining");

endmodule

`default_nettype wire

// ----- tb/sv/mqtt_hdr_checker.sv -----
// Scoreboard for the MQTT inbound header parser: tracks the rx and pkt channels,
// predicts every packet header from the accepted bytes and compares it.
// Depends on mqtt_hdr_pkg.
`timescale 1ns / 100ps

module mqtt_hdr_checker (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           rx_valid,
  input  wire logic                           rx_ready,
  input  wire logic [7:0]                     rx_data_byte,
  input  wire logic                           rx_chunk_start,
  input  wire logic                           pkt_valid,
  input  wire logic                           pkt_ready,
  input  wire logic [3:0]                     pkt_packet_type,
  input  wire logic [mqtt_hdr_pkg::LEN_W-1:0] pkt_remaining_length,
  input  wire logic                           pkt_is_connack,
  input  wire logic [7:0]                     pkt_connack_code,
  output int                                  fail_count,
  output int                                  outstanding
);

  localparam int unsigned LW = mqtt_hdr_pkg::LEN_W;

  typedef enum logic [1:0] {PH_TYPE, PH_LEN, PH_BODY} phase_e;

  // Parser shadow state
  phase_e           phase;
  logic [3:0]       type_q;
  logic [LW-1:0]    len_acc;
  logic [2:0]       len_cnt;
  logic [LW-1:0]    body_left;
  logic [1:0]       body_idx;
  logic [7:0]       code_q;

  mqtt_hdr_pkg::pkt_item_t pending_hdrs[$];
  int                      errs;

  // Advance the shadow parser by one byte; returns 1 when a packet completes.
  function automatic bit parse_byte(input logic [7:0] b, input logic start,
                                    output mqtt_hdr_pkg::pkt_item_t hdr);
    bit done;
    done = 1'b0;
    hdr  = '0;
    if (start) phase = PH_TYPE;
    case (phase)
      PH_TYPE: begin
        type_q    = b[7:4];
        len_acc   = '0;
        len_cnt   = '0;
        body_left = '0;
        body_idx  = '0;
        code_q    = mqtt_hdr_pkg::NO_CODE;
        phase     = PH_LEN;
      end
      PH_LEN: begin
        len_acc = len_acc | (LW'(b[6:0]) << (7 * len_cnt[1:0]));
        len_cnt = len_cnt + 3'd1;
        // the last allowed length byte closes the field regardless of bit 7
        if (!b[7] || len_cnt >= mqtt_hdr_pkg::MAX_LENGTH_BYTES) begin
          if (len_acc == '0) begin
            done = 1'b1;
          end else begin
            body_left = len_acc;
            phase     = PH_BODY;
          end
        end
      end
      default: begin
        if (body_idx == 2'd1) code_q = b;
        if (body_idx < 2'd2) body_idx = body_idx + 2'd1;
        body_left = body_left - 1'b1;
        if (body_left == '0) done = 1'b1;
      end
    endcase
    if (done) begin
      hdr.packet_type      = type_q;
      hdr.remaining_length = len_acc;
      hdr.is_connack       = (type_q == mqtt_hdr_pkg::CONNACK_TYPE);
      hdr.connack_code     = hdr.is_connack ? code_q : 8'h00;
      phase                = PH_TYPE;
    end
    return done;
  endfunction

  initial begin
    errs = 0;
  end

  always @(posedge clk) begin
    mqtt_hdr_pkg::pkt_item_t want;
    mqtt_hdr_pkg::pkt_item_t got;
    bit                      emitted;
    if (rst) begin
      phase     = PH_TYPE;
      type_q    = '0;
      len_acc   = '0;
      len_cnt   = '0;
      body_left = '0;
      body_idx  = '0;
      code_q    = mqtt_hdr_pkg::NO_CODE;
      pending_hdrs.delete();
    end else begin
      if (rx_valid && rx_ready) begin
        emitted = parse_byte(rx_data_byte, rx_chunk_start, want);
        if (emitted) pending_hdrs.push_back(want);
      end
      if (pkt_valid && pkt_ready) begin
        got.packet_type      = pkt_packet_type;
        got.remaining_length = pkt_remaining_length;
        got.is_connack       = pkt_is_connack;
        got.connack_code     = pkt_connack_code;
        if (pending_hdrs.size() == 0) begin
          errs++;
          if (errs <= 10)
            $display("[%0t] unexpected header: type=%h len=%0d connack=%b code=%h",
                     $realtime, got.packet_type, got.remaining_length,
                     got.is_connack, got.connack_code);
        end else begin
          want = pending_hdrs.pop_front();
          if (got !== want) begin
            errs++;
            if (errs <= 10) begin
              $display("[%0t] header mismatch: exp type=%h len=%0d connack=%b code=%h",
                       $realtime, want.packet_type, want.remaining_length,
                       want.is_connack, want.connack_code);
              $display("    got type=%h len=%0d connack=%b code=%h",
                       got.packet_type, got.remaining_length,
                       got.is_connack, got.connack_code);
            end
          end
        end
      end
    end
    outstanding <= pending_hdrs.size();
    fail_count  <= errs;
  end

endmodule

// ----- tb/sv/tb_mqtt_inbound_header_parser_core.sv -----
// Testbench top for mqtt_inbound_header_parser_core: clock, reset, byte stimulus,
// output back-pressure and verdict. Depends on mqtt_hdr_pkg, both channel
// interfaces and mqtt_hdr_checker.
`timescale 1ns / 100ps

module tb_mqtt_inbound_header_parser_core;

  localparam int unsigned CYCLE_LIMIT  = 200000;  // far above the slowest legal run
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES  = 60;      // long output stall for the fill test

  logic clk;
  logic rst;

  mqtt_hdr_rx_if  rx();
  mqtt_hdr_pkt_if pkt();

  int          fail_count;
  int          outstanding;
  int unsigned cycles;
  int unsigned bytes_sent;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          hold_toggle;   // flipped by stimulus to request a long output stall
  bit          force_start;   // next packet must resync with chunk_start

  mqtt_inbound_header_parser_core dut (
    .clk (clk),
    .rst (rst),
    .rx  (rx),
    .pkt (pkt)
  );

  mqtt_hdr_checker chk (
    .clk                  (clk),
    .rst                  (rst),
    .rx_valid             (rx.valid),
    .rx_ready             (rx.ready),
    .rx_data_byte         (rx.data_byte),
    .rx_chunk_start       (rx.chunk_start),
    .pkt_valid            (pkt.valid),
    .pkt_ready            (pkt.ready),
    .pkt_packet_type      (pkt.packet_type),
    .pkt_remaining_length (pkt.remaining_length),
    .pkt_is_connack       (pkt.is_connack),
    .pkt_connack_code     (pkt.connack_code),
    .fail_count           (fail_count),
    .outstanding          (outstanding)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Watchdog: a hung handshake or a missing header ends here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Output side: random ready drops, plus a long hold-off counted here when
  // the stimulus flips hold_toggle. The hold lets the two-entry output buffer
  // fill so that rx.ready has to fall.
  initial begin
    bit          hold_seen;
    int unsigned hold_left;
    hold_seen = 1'b0;
    hold_left = 0;
    pkt.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_toggle != hold_seen) begin
        hold_seen = hold_toggle;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pkt.ready <= 1'b0;
      end else begin
        pkt.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // One byte transaction, with random idle cycles in front of it.
  task automatic send_byte(input logic [7:0] d, input logic s);
    while ($urandom_range(99) < send_idle_pct) begin
      rx.valid <= 1'b0;
      @(posedge clk);
    end
    rx.valid       <= 1'b1;
    rx.data_byte   <= d;
    rx.chunk_start <= s;
    @(posedge clk);
    while (!rx.ready) @(posedge clk);
    bytes_sent++;
  endtask

  // Type byte plus remaining-length field. pad adds redundant zero groups
  // (non-minimal encoding, capped at four bytes); cont4 sets bit 7 on a
  // fourth length byte, which the parser must ignore.
  task automatic send_header(input logic [7:0] first, input logic start,
                             input int unsigned len, input int unsigned pad,
                             input bit cont4);
    int unsigned n;
    int unsigned total;
    logic [7:0]  lb;
    n = 1;
    while (n < 4 && (len >> (7 * n)) != 0) n++;
    total = (n + pad > 4) ? 4 : n + pad;
    send_byte(first, start);
    for (int i = 0; i < total; i++) begin
      lb = 8'((len >> (7 * i)) & 32'h7F);
      if (i < total - 1 || (total == 4 && cont4)) lb[7] = 1'b1;
      send_byte(lb, 1'b0);
    end
  endtask

  task automatic send_body(input int unsigned n);
    repeat (n) send_byte(8'($urandom_range(255)), 1'b0);
  endtask

  // Mostly short bodies; some of 100 to 200 bytes; optionally huge ones that
  // are never completed.
  function automatic int unsigned pick_len(input bit allow_huge);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return $urandom_range(4);
    if (r < 82) return $urandom_range(5, 20);
    if (r < 94 || !allow_huge) return $urandom_range(100, 200);
    return $urandom_range(16384, 32'h0FFF_FFFF);
  endfunction

  // Close the input and wait until every predicted header has been taken.
  // The first edge lets the checker count the last accepted byte.
  task automatic drain();
    rx.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Random traffic: mostly complete packets with random content, some
  // packets cut short by a new chunk, some raw noise. Anything that may
  // leave the parser mid-packet makes the next packet resync via chunk_start.
  task automatic run_random(input int unsigned n_bytes);
    int unsigned target;
    int unsigned kind;
    int unsigned len;
    int unsigned cut;
    logic [7:0]  first;
    logic        start;
    target = bytes_sent + n_bytes;
    while (bytes_sent < target) begin
      kind  = $urandom_range(99);
      first = {($urandom_range(9) < 3) ? mqtt_hdr_pkg::CONNACK_TYPE
                                       : 4'($urandom_range(15)),
               4'($urandom_range(15))};
      start = force_start | 1'($urandom_range(1));
      force_start = 1'b0;
      if (kind < 75) begin
        len = pick_len(1'b0);
        send_header(first, start, len,
                    ($urandom_range(9) == 0) ? $urandom_range(1, 3) : 0,
                    1'($urandom_range(1)));
        send_body(len);
      end else if (kind < 90) begin
        len = pick_len(1'b1);
        cut = (len > 1) ? $urandom_range((len > 6) ? 5 : len - 1) : 0;
        send_header(first, start, len, 0, 1'($urandom_range(1)));
        send_body(cut);
        force_start = 1'b1;
      end else begin
        repeat ($urandom_range(1, 4))
          send_byte(8'($urandom_range(255)), ($urandom_range(9) == 0));
        force_start = 1'b1;
      end
    end
  endtask

  initial begin
    rst            = 1'b1;
    rx.valid       = 1'b0;
    rx.data_byte   = 8'h00;
    rx.chunk_start = 1'b0;
    hold_toggle    = 1'b0;
    force_start    = 1'b1;
    bytes_sent     = 0;
    send_idle_pct  = 11;
    recv_idle_pct  = 63;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---- directed ----
    // CONNACK with a full two-byte body: return code 0x05
    send_header({mqtt_hdr_pkg::CONNACK_TYPE, 4'h0}, 1'b1, 2, 0, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h05, 1'b0);
    // zero-length CONNACK: header closes on its length byte, code stays 0xFF
    send_header({mqtt_hdr_pkg::CONNACK_TYPE, 4'h0}, 1'b0, 0, 0, 1'b0);
    // one-byte CONNACK body: too short for a code
    send_header({mqtt_hdr_pkg::CONNACK_TYPE, 4'hF}, 1'b0, 1, 0, 1'b0);
    send_byte(8'hAA, 1'b0);
    // maximum length with continuation on the fourth byte, then a new chunk
    // drops the unfinished packet
    send_header(8'hF0, 1'b0, 32'h0FFF_FFFF, 0, 1'b1);
    send_byte(8'hFF, 1'b0);
    // non-CONNACK after the abort: code reported as zero
    send_header(8'h35, 1'b1, 1, 0, 1'b0);
    send_byte(8'hFF, 1'b0);
    // all-zero length spread over four bytes
    send_header(8'h00, 1'b0, 0, 3, 1'b0);
    // new chunk in the middle of a CONNACK body
    send_header({mqtt_hdr_pkg::CONNACK_TYPE, 4'h0}, 1'b0, 3, 0, 1'b0);
    send_byte(8'h11, 1'b0);
    send_header(8'hD0, 1'b1, 0, 0, 1'b0);

    // ---- random, sender mostly busy, receiver often stalled ----
    run_random(160);
    // sender pause until the output side has caught up
    drain();

    send_idle_pct = 63;
    recv_idle_pct <= 11;
    run_random(160);

    // ---- no idling; long output hold-off with back-to-back short packets ----
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    hold_toggle   <= ~hold_toggle;
    send_header(8'h20, 1'b1, 0, 0, 1'b0);
    repeat (23) send_header(8'($urandom_range(255)), 1'b0, 0, 0, 1'b0);
    force_start = 1'b1;
    run_random(150);

    drain();
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/mqtt_hdr_pkg.sv
hw/rtl/mqtt_hdr_rx_if.sv
hw/rtl/mqtt_hdr_pkt_if.sv
hw/rtl/mqtt_inbound_header_parser_core.sv
tb/sv/mqtt_hdr_checker.sv
tb/sv/tb_mqtt_inbound_header_parser_core.sv
